// ----- sv/vrple_pkg.sv -----
// ----------------------------------------------------------------------------
// vrple_pkg
// Shared widths, constants and helpers for the route length evaluator.
// ----------------------------------------------------------------------------
package vrple_pkg;

  // Fixed field widths.
  localparam int unsigned CoordW  = 16;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned LenW    = 40;
  localparam int unsigned LoadW   = 17;

  // Customer table depth and distance fraction bits.
  localparam int unsigned MaxCustomers = 256;
  localparam int unsigned FracBits     = 8;

  // Square root sizing: the radicand is dx^2 + dy^2 scaled by 2^(2*FracBits).
  localparam int unsigned SumW   = 2 * CoordW + 1;
  localparam int unsigned RadW   = SumW + 2 * FracBits + ((SumW + 2 * FracBits) % 2);
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 3;
  localparam int unsigned DepotW = RootW + 1;

  localparam logic [LenW-1:0] LenMax = '1;

  // One customer table entry.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] demand;
  } customer_t;

  // Saturating add of two lengths.
  function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                               input logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? LenMax : s[LenW-1:0];
  endfunction

endpackage

// ----- sv/vrple_if.sv -----
// ----------------------------------------------------------------------------
// vrple_in_if / vrple_out_if
// Valid/ready channels for requests in and route results out.
// ----------------------------------------------------------------------------
interface vrple_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  customer_index;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [15:0] demand;
  logic        last_gene;

  modport source(output valid, operation, customer_index, coord_x, coord_y, demand,
                 last_gene, input ready);
  modport sink(input valid, operation, customer_index, coord_x, coord_y, demand,
               last_gene, output ready);
endinterface

interface vrple_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] route_length;
  logic        used_alt_depot;
  logic [39:0] total_path;
  logic        chromosome_done;

  modport source(output valid, route_length, used_alt_depot, total_path,
                 chromosome_done, input ready);
  modport sink(input valid, route_length, used_alt_depot, total_path,
               chromosome_done, output ready);
endinterface

// ----- sv/vrp_route_length_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// vrp_route_length_evaluator_top
// A load request writes the customer table. Each distance runs on the
// shared bit-serial root unit (25 root bits). A gene that opens a route needs
// no distance, one that extends a route needs one, one that closes a route
// needs four, and one that ends the chromosome needs four more; a result may
// also wait on a full output register. Requests are not taken meanwhile.
// Reset clears route state, sets capacity to 65535 and depots to zero.
// ----------------------------------------------------------------------------
module vrp_route_length_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrple_in_if.sink    in_i,
  vrple_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CoordW = vrple_pkg::CoordW;
  localparam int unsigned LenW   = vrple_pkg::LenW;
  localparam int unsigned LoadW  = vrple_pkg::LoadW;
  localparam int unsigned RootW  = vrple_pkg::RootW;
  localparam int unsigned DepW   = vrple_pkg::DepotW;
  localparam int unsigned AddrW  = $clog2(vrple_pkg::MaxCustomers);

  // Register indexes.
  localparam logic [2:0] RegCap  = 3'd0;
  localparam logic [2:0] RegDx   = 3'd1;
  localparam logic [2:0] RegDy   = 3'd2;
  localparam logic [2:0] RegAx   = 3'd3;
  localparam logic [2:0] RegAy   = 3'd4;

  // Operations.
  localparam logic OpLoad = 1'b0;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFetch = 3'd1;
  localparam logic [2:0] StSqX   = 3'd2;
  localparam logic [2:0] StSqY   = 3'd3;
  localparam logic [2:0] StRoot  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;
  localparam logic [2:0] StLast  = 3'd6;

  // Distance jobs.
  localparam logic [2:0] JobExt = 3'd0;
  localparam logic [2:0] JobMf  = 3'd1;
  localparam logic [2:0] JobMp  = 3'd2;
  localparam logic [2:0] JobAf  = 3'd3;
  localparam logic [2:0] JobAp  = 3'd4;

  // Configuration registers.
  logic [CoordW-1:0] cap_q, dep_x_q, dep_y_q, alt_x_q, alt_y_q;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= '1;
      dep_x_q <= '0;
      dep_y_q <= '0;
      alt_x_q <= '0;
      alt_y_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegCap:  cap_q   <= pwdata[CoordW-1:0];
        RegDx:   dep_x_q <= pwdata[CoordW-1:0];
        RegDy:   dep_y_q <= pwdata[CoordW-1:0];
        RegAx:   alt_x_q <= pwdata[CoordW-1:0];
        RegAy:   alt_y_q <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (cfg_idx)
      RegCap:  prdata = {16'd0, cap_q};
      RegDx:   prdata = {16'd0, dep_x_q};
      RegDy:   prdata = {16'd0, dep_y_q};
      RegAx:   prdata = {16'd0, alt_x_q};
      RegAy:   prdata = {16'd0, alt_y_q};
      default: prdata = '0;
    endcase
  end

  // Sequencer and route state.
  logic [2:0]        state_q, state_d;
  logic [2:0]        job_q, job_d;
  logic              last_q, last_d;
  logic              done_q, done_d;
  logic              open_q, open_d;
  logic [LoadW-1:0]  load_q, load_d;
  logic [LenW-1:0]   inner_q, inner_d;
  logic [LenW-1:0]   path_q, path_d;
  logic [CoordW-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  vrple_pkg::customer_t cur_q, cur_d;
  logic [DepW-1:0]   dm_q, dm_d, da_q, da_d;
  logic [2*CoordW-1:0] sq_q, sq_d;

  // Output register.
  logic              ovalid_q, ovalid_d;
  logic [LenW-1:0]   olen_q, olen_d, otot_q, otot_d;
  logic              oalt_q, oalt_d, odone_q, odone_d;

  // Customer table.
  logic                 ram_we, ram_re;
  vrple_pkg::customer_t ram_wdata, ram_rdata;
  logic [AddrW-1:0]     ram_addr;

  // Shared distance datapath.
  logic [CoordW-1:0]   ax, ay, bx, by, dx, dy, dsel;
  logic [2*CoordW-1:0] prod;
  logic [vrple_pkg::SumW-1:0] sq_sum;
  logic                sqrt_start, sqrt_done;
  logic [RootW-1:0]    root;

  // Internal helpers.
  logic              in_acc;
  logic              alt_sel;
  logic [DepW-1:0]   depot_cost;
  logic [LenW-1:0]   route_len, new_path;
  logic [LoadW:0]    load_sum;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StIdle);
  assign ram_addr  = in_i.customer_index[AddrW-1:0];
  assign ram_we    = in_acc && (in_i.operation == OpLoad);
  assign ram_re    = in_acc && (in_i.operation != OpLoad);
  assign ram_wdata = '{x: in_i.coord_x, y: in_i.coord_y, demand: in_i.demand};

  vrple_ram #(
    .Width($bits(vrple_pkg::customer_t)),
    .Depth(vrple_pkg::MaxCustomers)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  // Operand selection for the distance in work.
  always_comb begin
    case (job_q)
      JobExt: begin ax = prev_x_q; ay = prev_y_q; bx = cur_q.x;   by = cur_q.y;   end
      JobMf:  begin ax = dep_x_q;  ay = dep_y_q;  bx = first_x_q; by = first_y_q; end
      JobMp:  begin ax = dep_x_q;  ay = dep_y_q;  bx = prev_x_q;  by = prev_y_q;  end
      JobAf:  begin ax = alt_x_q;  ay = alt_y_q;  bx = first_x_q; by = first_y_q; end
      JobAp:  begin ax = alt_x_q;  ay = alt_y_q;  bx = prev_x_q;  by = prev_y_q;  end
      default: begin ax = '0; ay = '0; bx = '0; by = '0; end
    endcase
  end

  // One shared squarer: x difference first, then y difference.
  assign dx     = (ax > bx) ? (ax - bx) : (bx - ax);
  assign dy     = (ay > by) ? (ay - by) : (by - ay);
  assign dsel   = (state_q == StSqX) ? dx : dy;
  assign prod   = dsel * dsel;
  assign sq_sum = {1'b0, sq_q} + {1'b0, prod};
  assign sqrt_start = (state_q == StSqY);

  vrple_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .sum_i  (sq_sum),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // Depot choice and totals for a closing route; ties go to the alternate.
  assign alt_sel    = !(dm_q < da_q);
  assign depot_cost = alt_sel ? da_q : dm_q;
  assign route_len  = vrple_pkg::sat_add(inner_q, LenW'(depot_cost));
  assign new_path   = vrple_pkg::sat_add(path_q, route_len);
  assign load_sum   = {1'b0, load_q} + (LoadW+1)'(ram_rdata.demand);

  // Gene sequencer.
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    last_d    = last_q;
    done_d    = done_q;
    open_d    = open_q;
    load_d    = load_q;
    inner_d   = inner_q;
    path_d    = path_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    cur_d     = cur_q;
    dm_d      = dm_q;
    da_d      = da_q;
    sq_d      = sq_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    olen_d    = olen_q;
    otot_d    = otot_q;
    oalt_d    = oalt_q;
    odone_d   = odone_q;

    case (state_q)
      StIdle: begin
        if (ram_re) begin
          last_d  = in_i.last_gene;
          done_d  = 1'b0;
          state_d = StFetch;
        end
      end
      StFetch: begin
        cur_d = ram_rdata;
        if (!open_q) begin
          // First customer opens a route.
          first_x_d = ram_rdata.x;
          first_y_d = ram_rdata.y;
          prev_x_d  = ram_rdata.x;
          prev_y_d  = ram_rdata.y;
          inner_d   = '0;
          load_d    = LoadW'(ram_rdata.demand);
          open_d    = 1'b1;
          state_d   = StLast;
        end else if (load_q == '0 || load_sum <= (LoadW+1)'(cap_q)) begin
          job_d   = JobExt;
          state_d = StSqX;
        end else begin
          job_d   = JobMf;
          state_d = StSqX;
        end
      end
      StSqX: begin
        sq_d    = prod;
        state_d = StSqY;
      end
      StSqY: begin
        state_d = StRoot;
      end
      StRoot: begin
        if (sqrt_done) begin
          case (job_q)
            JobExt: begin
              inner_d  = vrple_pkg::sat_add(inner_q, LenW'(root));
              prev_x_d = cur_q.x;
              prev_y_d = cur_q.y;
              load_d   = load_q + LoadW'(cur_q.demand);
              state_d  = StLast;
            end
            JobMf: begin
              dm_d    = DepW'(root);
              job_d   = JobMp;
              state_d = StSqX;
            end
            JobMp: begin
              dm_d    = dm_q + DepW'(root);
              job_d   = JobAf;
              state_d = StSqX;
            end
            JobAf: begin
              da_d    = DepW'(root);
              job_d   = JobAp;
              state_d = StSqX;
            end
            default: begin
              da_d    = da_q + DepW'(root);
              state_d = StEmit;
            end
          endcase
        end
      end
      StEmit: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          olen_d   = route_len;
          otot_d   = new_path;
          oalt_d   = alt_sel;
          odone_d  = done_q;
          if (done_q) begin
            load_d  = '0;
            inner_d = '0;
            path_d  = '0;
            open_d  = 1'b0;
            state_d = StIdle;
          end else begin
            // The customer that overflowed opens the next route.
            path_d    = new_path;
            first_x_d = cur_q.x;
            first_y_d = cur_q.y;
            prev_x_d  = cur_q.x;
            prev_y_d  = cur_q.y;
            inner_d   = '0;
            load_d    = LoadW'(cur_q.demand);
            open_d    = 1'b1;
            state_d   = StLast;
          end
        end
      end
      StLast: begin
        if (last_q) begin
          done_d  = 1'b1;
          job_d   = JobMf;
          state_d = StSqX;
        end else begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and route state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      job_q     <= JobExt;
      last_q    <= 1'b0;
      done_q    <= 1'b0;
      open_q    <= 1'b0;
      load_q    <= '0;
      inner_q   <= '0;
      path_q    <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      job_q     <= job_d;
      last_q    <= last_d;
      done_q    <= done_d;
      open_q    <= open_d;
      load_q    <= load_d;
      inner_q   <= inner_d;
      path_q    <= path_d;
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    dm_q    <= dm_d;
    da_q    <= da_d;
    sq_q    <= sq_d;
    olen_q  <= olen_d;
    otot_q  <= otot_d;
    oalt_q  <= oalt_d;
    odone_q <= odone_d;
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.route_length    = olen_q;
  assign out_o.used_alt_depot  = oalt_q;
  assign out_o.total_path      = otot_q;
  assign out_o.chromosome_done = odone_q;

endmodule

// ----- sv/vrple_ram.sv -----
// ----------------------------------------------------------------------------
// vrple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrple_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/vrple_sqrt.sv -----
// ----------------------------------------------------------------------------
// vrple_sqrt
// Bit-serial integer square root of a scaled sum of squares, one root bit
// per cycle.
// ----------------------------------------------------------------------------
module vrple_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vrple_pkg::SumW-1:0]   sum_i,
  output logic                         done_o,
  output logic [vrple_pkg::RootW-1:0]  root_o
);

  localparam int unsigned RadW  = vrple_pkg::RadW;
  localparam int unsigned RootW = vrple_pkg::RootW;
  localparam int unsigned RemW  = vrple_pkg::RemW;
  localparam int unsigned CntW  = $clog2(RootW + 1);
  localparam int unsigned PadW  = 2 * vrple_pkg::FracBits;
  localparam int unsigned TopW  = RadW - vrple_pkg::SumW - PadW;

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RemW-1:0]  rem_n;
  logic [RemW-1:0]  trial;

  // One restoring step: bring down two radicand bits and try a root bit.
  always_comb begin
    rem_n  = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {{(RemW-RootW-2){1'b0}}, root_q, 2'b01};
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // The radicand is the sum scaled by 2^(2*FracBits), with a zero on top
      // to make the width even.
      rad_d  = {{TopW{1'b0}}, sum_i, {PadW{1'b0}}};
      root_d = '0;
      rem_d  = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
